// ===== rtl/core/lmfbs_pkg.sv =====
// shared types and constants of the led matrix frame buffer scanner
// no dependencies

package lmfbs_pkg;

  localparam int unsigned LMFBS_ROWS    = 8;
  localparam int unsigned LMFBS_COLUMNS = 16;
  localparam int unsigned LMFBS_COMMONS = 8;

  localparam int unsigned OP_W    = 4;
  localparam int unsigned ROW_W   = 4;
  localparam int unsigned COL_W   = 4;
  localparam int unsigned WIDTH_W = 5;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned IDX_W   = 3;

  localparam logic [OP_W-1:0] OP_WRITE   = 4'd0;
  localparam logic [OP_W-1:0] OP_SPRITE  = 4'd1;
  localparam logic [OP_W-1:0] OP_LEFT    = 4'd2;
  localparam logic [OP_W-1:0] OP_RIGHT   = 4'd3;
  localparam logic [OP_W-1:0] OP_UP      = 4'd4;
  localparam logic [OP_W-1:0] OP_DOWN    = 4'd5;
  localparam logic [OP_W-1:0] OP_SCAN    = 4'd6;
  localparam logic [OP_W-1:0] OP_REFRESH = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR   = 4'd8;

  // command broadcast to every row cell
  typedef struct packed {
    logic              en;
    logic [OP_W-1:0]   op;
    logic              wrap;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] bits;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/lmfbs_if.sv =====
// command and scan result channels of the led matrix frame buffer scanner
// depends on lmfbs_pkg

interface lmfbs_in_if;
  import lmfbs_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic               wrap;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   column;
  logic [WIDTH_W-1:0] width;
  logic [DATA_W-1:0]  row_data;

  modport source (output valid, op, wrap, row, column, width, row_data, input ready);
  modport sink   (input valid, op, wrap, row, column, width, row_data, output ready);
endinterface

interface lmfbs_out_if;
  import lmfbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  common_index;
  logic [DATA_W-1:0] serial_bits;
  logic              last;

  modport source (output valid, common_index, serial_bits, last, input ready);
  modport sink   (input valid, common_index, serial_bits, last, output ready);
endinterface

// ===== rtl/core/lmfbs_row_cell.sv =====
// one image row of the frame buffer; takes rows from its neighbors on vertical shifts
// depends on lmfbs_pkg

module lmfbs_row_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lmfbs_pkg::cell_ctrl_t     ctrl_i,
  input  logic                      sel_i,
  input  logic [lmfbs_pkg::DATA_W-1:0] above_i,
  input  logic [lmfbs_pkg::DATA_W-1:0] below_i,
  input  logic [lmfbs_pkg::IDX_W-1:0]  common_i,
  output logic [lmfbs_pkg::DATA_W-1:0] row_o,
  output logic                      lo_bit_o,
  output logic                      hi_bit_o
);
  import lmfbs_pkg::*;

  logic [DATA_W-1:0] row_q, row_d;

  always_comb begin
    row_d = row_q;
    case (ctrl_i.op)
      OP_WRITE:  if (sel_i) row_d = ctrl_i.data;
      OP_SPRITE: if (sel_i) row_d = (row_q & ~ctrl_i.mask) | (ctrl_i.bits & ctrl_i.mask);
      OP_LEFT:   row_d = {row_q[DATA_W-2:0], ctrl_i.wrap & row_q[DATA_W-1]};
      OP_RIGHT:  row_d = {ctrl_i.wrap & row_q[0], row_q[DATA_W-1:1]};
      OP_UP:     row_d = below_i;
      OP_DOWN:   row_d = above_i;
      OP_CLEAR:  row_d = '0;
      default:   row_d = row_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (ctrl_i.en) begin
      row_q <= row_d;
    end
  end

  assign row_o    = row_q;
  assign lo_bit_o = row_q[{1'b0, common_i}];
  assign hi_bit_o = row_q[{1'b1, common_i}];

endmodule

// ===== rtl/core/led_matrix_frame_buffer_scanner.sv =====
// top level: chain of row cells, sprite mask logic, scan sequencer and output register
// depends on lmfbs_pkg, lmfbs_in_if, lmfbs_out_if and lmfbs_row_cell

// Image commands update the image in a chain of row cells: write row and sprite
// row change the selected row only, shifts and clear change all rows at once;
// a scan step yields one beat. A full refresh yields eight beats, one per cycle
// while the output is taken, paced by the scan sequencer; no command is accepted
// until the last of them is in the output register. A result waiting in the
// output register holds off new commands until it is taken or taken in the same
// cycle. After reset the image is all zeros and the common index is zero.
module led_matrix_frame_buffer_scanner #(
  parameter int unsigned ROWS = lmfbs_pkg::LMFBS_ROWS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lmfbs_in_if.sink           in_i,
  lmfbs_out_if.source        out_o
);
  import lmfbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'b01,
    ST_REFRESH = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  scan_idx_q, scan_idx_d;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [DATA_W-1:0] out_bits_q, out_bits_d;
  logic              out_last_q, out_last_d;

  logic              out_free, in_ready, accept;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] rows [ROWS];
  logic [ROWS-1:0]   lo_bits, hi_bits;
  logic [DATA_W-1:0] serial;

  // sprite placement: image bit b takes sprite bit b + column + width - 16
  logic [WIDTH_W:0]  span;
  logic [WIDTH_W:0]  clip_end;
  logic [DATA_W:0]   low_fill;
  logic [DATA_W-1:0] sprite_mask, sprite_bits;

  always_comb begin
    span     = (WIDTH_W+1)'(in_i.width) + (WIDTH_W+1)'(in_i.column);
    clip_end = (span >= (WIDTH_W+1)'(LMFBS_COLUMNS)) ? (WIDTH_W+1)'(LMFBS_COLUMNS) : span;
    low_fill = ((DATA_W+1)'(1) << ((WIDTH_W+1)'(LMFBS_COLUMNS) - clip_end)) - (DATA_W+1)'(1);
    sprite_mask = ({DATA_W{1'b1}} >> in_i.column) & ~low_fill[DATA_W-1:0];
    if (span >= (WIDTH_W+1)'(LMFBS_COLUMNS)) begin
      sprite_bits = in_i.row_data >> (span - (WIDTH_W+1)'(LMFBS_COLUMNS));
    end else begin
      sprite_bits = in_i.row_data << ((WIDTH_W+1)'(LMFBS_COLUMNS) - span);
    end
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign in_ready = (state_q == ST_IDLE) && out_free;
  assign accept   = in_i.valid && in_ready;

  always_comb begin
    ctrl.en   = accept;
    ctrl.op   = in_i.op;
    ctrl.wrap = in_i.wrap;
    ctrl.data = in_i.row_data;
    ctrl.mask = sprite_mask;
    ctrl.bits = sprite_bits;
  end

  for (genvar i = 0; i < ROWS; i++) begin : g_cell
    logic [DATA_W-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = in_i.wrap ? rows[ROWS-1] : '0;
    end else begin : g_mid_a
      assign above = rows[i-1];
    end
    if (i == ROWS-1) begin : g_bot
      assign below = in_i.wrap ? rows[0] : '0;
    end else begin : g_mid_b
      assign below = rows[i+1];
    end

    lmfbs_row_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sel_i    (in_i.row == ROW_W'(i)),
      .above_i  (above),
      .below_i  (below),
      .common_i (scan_idx_q),
      .row_o    (rows[i]),
      .lo_bit_o (lo_bits[i]),
      .hi_bit_o (hi_bits[i])
    );
  end

  // low half of the serial word from row j, high half from row j at ROWS + j
  for (genvar k = 0; k < DATA_W; k++) begin : g_serial
    if (k < ROWS) begin : g_lo
      assign serial[k] = lo_bits[k];
    end else if (k < 2 * ROWS) begin : g_hi
      assign serial[k] = hi_bits[k-ROWS];
    end else begin : g_none
      assign serial[k] = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    scan_idx_d  = scan_idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_idx_d   = out_idx_q;
    out_bits_d  = out_bits_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_i.op == OP_SCAN) begin
          out_valid_d = 1'b1;
          out_idx_d   = scan_idx_q;
          out_bits_d  = serial;
          out_last_d  = 1'b1;
          scan_idx_d  = scan_idx_q + IDX_W'(1);
        end else if (accept && in_i.op == OP_REFRESH) begin
          scan_idx_d = '0;
          state_d    = ST_REFRESH;
        end
      end
      ST_REFRESH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = scan_idx_q;
          out_bits_d  = serial;
          out_last_d  = (scan_idx_q == IDX_W'(LMFBS_COMMONS - 1));
          scan_idx_d  = scan_idx_q + IDX_W'(1);
          if (scan_idx_q == IDX_W'(LMFBS_COMMONS - 1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q  <= out_idx_d;
    out_bits_q <= out_bits_d;
    out_last_q <= out_last_d;
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.common_index = out_idx_q;
  assign out_o.serial_bits  = out_bits_q;
  assign out_o.last         = out_last_q;

`ifndef NO_ASSERTIONS
  a_no_cmd_in_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REFRESH) |-> !in_ready) else $error("command accepted during refresh");

  a_non_last_from_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (state_q == ST_REFRESH))
    else $error("non-final beat outside refresh");

  a_refresh_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_REFRESH) |-> (scan_idx_q == '0))
    else $error("refresh did not restart at common zero");
`endif

endmodule

// ===== tb/lmfbs_scan_checker.sv =====
// scoreboard of the led matrix frame buffer scanner: mirrors the image and the
// common index, predicts every scan beat and compares the beats taken at the output
// depends on lmfbs_pkg, lmfbs_in_if and lmfbs_out_if

module lmfbs_scan_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  lmfbs_in_if         cmd_i,
  lmfbs_out_if        scan_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import lmfbs_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  common_index;
    logic [DATA_W-1:0] serial_bits;
    logic              last;
  } scan_beat_t;

  logic [DATA_W-1:0] frame_rows [LMFBS_ROWS];
  logic [IDX_W-1:0]  next_common;
  scan_beat_t        scan_beats_q [$];

  // bit d of each row, then bit 8+d of each row, for the current common d
  task automatic push_scan(input logic is_last);
    scan_beat_t b;
    b.common_index = next_common;
    b.serial_bits  = '0;
    b.last         = is_last;
    for (int j = 0; j < LMFBS_ROWS; j++) begin
      if (j < DATA_W) b.serial_bits[j] = frame_rows[j][next_common];
      if (LMFBS_ROWS + j < DATA_W) b.serial_bits[LMFBS_ROWS + j] = frame_rows[j][8 + next_common];
    end
    scan_beats_q.push_back(b);
    next_common = next_common + 1'b1;
  endtask

  always @(posedge clk_i) begin : track
    scan_beat_t        want;
    logic [DATA_W-1:0] keep;
    int                lim;
    int                pos;
    if (!rst_ni) begin
      foreach (frame_rows[i]) frame_rows[i] = '0;
      next_common  = '0;
      fail_count_o = 0;
      scan_beats_q.delete();
    end else begin
      // compare first: a beat taken now never belongs to a command taken now
      if (scan_i.valid && scan_i.ready) begin
        if (scan_beats_q.size() == 0) begin
          $error("unexpected scan beat: common_index %0d serial_bits %h last %0d",
                 scan_i.common_index, scan_i.serial_bits, scan_i.last);
          fail_count_o++;
        end else begin
          want = scan_beats_q.pop_front();
          if (scan_i.common_index !== want.common_index) begin
            $error("common_index: expected %0d, actual %0d", want.common_index,
                   scan_i.common_index);
            fail_count_o++;
          end
          if (scan_i.serial_bits !== want.serial_bits) begin
            $error("serial_bits: expected %h, actual %h", want.serial_bits,
                   scan_i.serial_bits);
            fail_count_o++;
          end
          if (scan_i.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, scan_i.last);
            fail_count_o++;
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        case (cmd_i.op)
          OP_WRITE: begin
            if (cmd_i.row < LMFBS_ROWS) frame_rows[cmd_i.row] = cmd_i.row_data;
          end
          OP_SPRITE: begin
            if (cmd_i.row < LMFBS_ROWS) begin
              lim = cmd_i.column + cmd_i.width;
              if (lim > LMFBS_COLUMNS) lim = LMFBS_COLUMNS;
              // sprite is msb first, column 0 is the row msb
              for (int c = cmd_i.column; c < lim; c++) begin
                pos = cmd_i.width - 1 - (c - cmd_i.column);
                frame_rows[cmd_i.row][LMFBS_COLUMNS - 1 - c] =
                  (pos < DATA_W) ? cmd_i.row_data[pos] : 1'b0;
              end
            end
          end
          OP_LEFT: begin
            foreach (frame_rows[i])
              frame_rows[i] = {frame_rows[i][DATA_W-2:0], cmd_i.wrap & frame_rows[i][DATA_W-1]};
          end
          OP_RIGHT: begin
            foreach (frame_rows[i])
              frame_rows[i] = {cmd_i.wrap & frame_rows[i][0], frame_rows[i][DATA_W-1:1]};
          end
          OP_UP: begin
            keep = frame_rows[0];
            for (int i = 1; i < LMFBS_ROWS; i++) frame_rows[i-1] = frame_rows[i];
            frame_rows[LMFBS_ROWS-1] = cmd_i.wrap ? keep : '0;
          end
          OP_DOWN: begin
            keep = frame_rows[LMFBS_ROWS-1];
            for (int i = LMFBS_ROWS - 1; i > 0; i--) frame_rows[i] = frame_rows[i-1];
            frame_rows[0] = cmd_i.wrap ? keep : '0;
          end
          OP_SCAN: push_scan(1'b1);
          OP_REFRESH: begin
            next_common = '0;
            for (int k = 0; k < LMFBS_COMMONS; k++) push_scan(k == LMFBS_COMMONS - 1);
          end
          OP_CLEAR: begin
            foreach (frame_rows[i]) frame_rows[i] = '0;
          end
          default: ;
        endcase
      end
    end
    pending_o = scan_beats_q.size();
  end

endmodule

// ===== tb/tb_led_matrix_frame_buffer_scanner.sv =====
// top of the led matrix frame buffer scanner testbench: clock, reset, command
// stimulus, output stalls, watchdog and verdict
// depends on lmfbs_pkg, lmfbs_in_if, lmfbs_out_if, the scanner and lmfbs_scan_checker

module tb_led_matrix_frame_buffer_scanner;
  import lmfbs_pkg::*;

  localparam int RANDOM_ITEMS   = 140;
  localparam int QUIET_TAIL     = 30;
  localparam int PRESSURE_AT    = 110;
  localparam int PRESSURE_SPAN  = 20;
  localparam int PRESSURE_HOLD  = 90;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               wrap;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic [WIDTH_W-1:0] width;
    logic [DATA_W-1:0]  row_data;
  } matrix_cmd_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;

  int sent         = 0;
  bit quiet        = 1'b0;
  bit tx_gaps_on   = 1'b1;
  bit rx_gaps_on   = 1'b1;
  bit hold_pending = 1'b0;

  lmfbs_in_if  cmd_if ();
  lmfbs_out_if scan_if ();

  led_matrix_frame_buffer_scanner uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (scan_if)
  );

  lmfbs_scan_checker scan_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_if),
    .scan_i       (scan_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic matrix_cmd_t make_cmd(input logic [OP_W-1:0] op, input logic wrap,
                                           input int row, input int column, input int width,
                                           input logic [DATA_W-1:0] data);
    matrix_cmd_t c;
    c.op       = op;
    c.wrap     = wrap;
    c.row      = ROW_W'(row);
    c.column   = COL_W'(column);
    c.width    = WIDTH_W'(width);
    c.row_data = data;
    return c;
  endfunction

  // called at a rising edge, returns at the edge where the beat is taken
  task automatic send_cmd(input matrix_cmd_t c);
    tx_gaps_on = !quiet && ((sent / 30) % 3 != 2) &&
                 !(sent >= PRESSURE_AT && sent < PRESSURE_AT + PRESSURE_SPAN);
    rx_gaps_on = !quiet && ((sent / 30) % 3 != 1);
    if (sent == PRESSURE_AT) hold_pending = 1'b1;
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.op       <= c.op;
    cmd_if.wrap     <= c.wrap;
    cmd_if.row      <= c.row;
    cmd_if.column   <= c.column;
    cmd_if.width    <= c.width;
    cmd_if.row_data <= c.row_data;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    sent++;
  endtask

  // output side: random stall bursts, plus one long hold-off so the block backs up
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    scan_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall_left   = PRESSURE_HOLD;
      end
      if (stall_left > 0) begin
        scan_if.ready <= 1'b0;
        stall_left--;
      end else begin
        scan_if.ready <= 1'b1;
        if (rx_gaps_on) begin
          if (run_left == 0) begin
            stall_left = $urandom_range(1, 13);
            run_left   = $urandom_range(1, 24);
          end else begin
            run_left--;
          end
        end
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (scan_if.valid && scan_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    matrix_cmd_t c;
    int          useful;
    int          sel;
    rst_ni          <= 1'b0;
    cmd_if.valid    <= 1'b0;
    cmd_if.op       <= OP_WRITE;
    cmd_if.wrap     <= 1'b0;
    cmd_if.row      <= '0;
    cmd_if.column   <= '0;
    cmd_if.width    <= '0;
    cmd_if.row_data <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset image, extremes, clipping, ignored rows, every shift, unused ops
    send_cmd(make_cmd(OP_SCAN,    1'b0, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(OP_WRITE,   1'b0, 0,  0,  0,  16'hFFFF));
    send_cmd(make_cmd(OP_WRITE,   1'b1, 7,  15, 31, 16'h8001));
    send_cmd(make_cmd(OP_WRITE,   1'b0, 8,  0,  0,  16'h1234));
    send_cmd(make_cmd(OP_REFRESH, 1'b0, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(OP_SPRITE,  1'b0, 3,  0,  16, 16'hA5C3));
    send_cmd(make_cmd(OP_SPRITE,  1'b0, 5,  12, 8,  16'h00F5));
    send_cmd(make_cmd(OP_SPRITE,  1'b0, 6,  15, 16, 16'hFFFF));
    send_cmd(make_cmd(OP_SPRITE,  1'b0, 2,  4,  0,  16'hFFFF));
    send_cmd(make_cmd(OP_SPRITE,  1'b0, 1,  0,  31, 16'hFFFF));
    send_cmd(make_cmd(OP_SPRITE,  1'b0, 15, 0,  16, 16'hFFFF));
    send_cmd(make_cmd(OP_LEFT,    1'b0, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(OP_LEFT,    1'b1, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(OP_RIGHT,   1'b0, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(OP_RIGHT,   1'b1, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(OP_UP,      1'b0, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(OP_UP,      1'b1, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(OP_DOWN,    1'b0, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(OP_DOWN,    1'b1, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(OP_SCAN,    1'b0, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(OP_REFRESH, 1'b1, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(4'd9,       1'b0, 0,  0,  0,  16'hFFFF));
    send_cmd(make_cmd(4'd15,      1'b1, 15, 15, 31, 16'hFFFF));
    send_cmd(make_cmd(OP_CLEAR,   1'b0, 0,  0,  0,  16'h0000));
    send_cmd(make_cmd(OP_SCAN,    1'b0, 0,  0,  0,  16'h0000));

    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      quiet = (useful >= RANDOM_ITEMS - QUIET_TAIL);
      sel   = $urandom_range(0, 99);
      if (sel < 18)      c.op = OP_WRITE;
      else if (sel < 36) c.op = OP_SPRITE;
      else if (sel < 44) c.op = OP_LEFT;
      else if (sel < 52) c.op = OP_RIGHT;
      else if (sel < 60) c.op = OP_UP;
      else if (sel < 68) c.op = OP_DOWN;
      else if (sel < 86) c.op = OP_SCAN;
      else if (sel < 92) c.op = OP_REFRESH;
      else if (sel < 94) c.op = OP_CLEAR;
      else               c.op = OP_W'($urandom_range(9, 15));
      // while the output is held off, keep offering writes and, mostly, scans that produce results
      if (sent >= PRESSURE_AT && sent < PRESSURE_AT + PRESSURE_SPAN)
        c.op = $urandom_range(0, 2) == 0 ? OP_WRITE : OP_SCAN;
      c.wrap     = 1'($urandom_range(0, 1));
      c.row      = ROW_W'($urandom_range(0, 9) == 0 ? $urandom_range(8, 15)
                                                    : $urandom_range(0, LMFBS_ROWS - 1));
      c.column   = COL_W'($urandom_range(0, 15));
      c.width    = WIDTH_W'($urandom_range(0, 7) == 0 ? $urandom_range(17, 31)
                                                      : $urandom_range(0, 16));
      c.row_data = DATA_W'($urandom);
      send_cmd(c);
      if (!(c.op > OP_CLEAR ||
            ((c.op == OP_WRITE || c.op == OP_SPRITE) && c.row >= LMFBS_ROWS)))
        useful++;
    end
    cmd_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lmfbs_pkg.sv
rtl/core/lmfbs_if.sv
rtl/core/lmfbs_row_cell.sv
rtl/core/led_matrix_frame_buffer_scanner.sv
tb/lmfbs_scan_checker.sv
tb/tb_led_matrix_frame_buffer_scanner.sv
